// ===== design/asl_pkg.sv =====
package asl_pkg;

  localparam logic [1:0] KIND_MNEMONIC = 2'd0;
  localparam logic [1:0] KIND_NUMBER   = 2'd1;
  localparam logic [1:0] KIND_COMMA    = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [15:0] SAT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [63:0] mnemonic_chars;
    logic [3:0]  mnemonic_length;
    logic        mnemonic_too_long;
    logic [15:0] number_value;
    logic        number_out_of_range;
    logic [15:0] line_number;
    logic [15:0] column_position;
    logic [15:0] token_index;
    logic        last_of_run;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == SAT_MAX) ? SAT_MAX : v + 16'd1;
  endfunction

endpackage

// ===== design/asl_if.sv =====
interface asl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_source;

  modport source (output valid, character, end_of_source, input ready);
  modport sink (input valid, character, end_of_source, output ready);
endinterface

interface asl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [63:0] mnemonic_chars;
  logic [3:0]  mnemonic_length;
  logic        mnemonic_too_long;
  logic [15:0] number_value;
  logic        number_out_of_range;
  logic [15:0] line_number;
  logic [15:0] column_position;
  logic [15:0] token_index;
  logic        last_of_run;

  modport source (output valid, token_kind, mnemonic_chars, mnemonic_length,
                  mnemonic_too_long, number_value, number_out_of_range,
                  line_number, column_position, token_index, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, mnemonic_chars, mnemonic_length,
                mnemonic_too_long, number_value, number_out_of_range,
                line_number, column_position, token_index, last_of_run,
                output ready);
endinterface

// ===== design/asl_core.sv =====
module asl_core #(
  parameter int MNEMONIC_CHARS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       character,
  input  logic             end_of_source,
  output asl_pkg::result_t res_first,
  output asl_pkg::result_t res_second,
  output logic [1:0]       res_count
);
  import asl_pkg::*;

  localparam int BufW = MNEMONIC_CHARS * 8;
  localparam int CntW = $clog2(MNEMONIC_CHARS + 1);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_LETTERS = 2'd1;
  localparam logic [1:0] MODE_DIGITS  = 2'd2;
  localparam logic [1:0] MODE_HALTED  = 2'd3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_VTAB    = 8'h0B;
  localparam logic [7:0] CHAR_FORM    = 8'h0C;
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;

  logic [1:0]      mode, mode_next;
  logic [BufW-1:0] letter_buffer, letter_buffer_next;
  logic [CntW-1:0] letter_count, letter_count_next;
  logic            letters_overflowed, letters_overflowed_next;
  logic [15:0]     number_accumulator, number_accumulator_next;
  logic            number_overflowed, number_overflowed_next;
  logic [15:0]     line_count, line_count_next;
  logic [15:0]     column_count, column_count_next;
  logic [15:0]     token_count, token_count_next;

  logic            is_letter, is_digit, is_space, halted, flush_start, tail_valid;
  logic [19:0]     digit_sum;
  result_t         res_flush, res_tail;

  // Builds the token for a pending letter or digit run.
  function automatic result_t run_token(input logic letters, input logic [63:0] chars,
                                        input logic [3:0] len, input logic too_long,
                                        input logic [15:0] value, input logic oor,
                                        input logic [15:0] line, input logic [15:0] col,
                                        input logic [15:0] idx);
    result_t r;
    r = '0;
    r.line_number     = line;
    r.column_position = col;
    r.token_index     = idx;
    if (letters) begin
      r.token_kind        = KIND_MNEMONIC;
      r.mnemonic_chars    = chars;
      r.mnemonic_length   = len;
      r.mnemonic_too_long = too_long;
    end else begin
      r.token_kind          = KIND_NUMBER;
      r.number_value        = value;
      r.number_out_of_range = oor;
    end
    return r;
  endfunction

  always_comb begin
    is_letter = (character >= CHAR_UPPER_A && character <= CHAR_UPPER_Z) ||
                (character >= CHAR_LOWER_A && character <= CHAR_LOWER_Z);
    is_digit  = character >= CHAR_ZERO && character <= CHAR_NINE;
    is_space  = character == CHAR_SPACE || character == CHAR_TAB ||
                character == CHAR_VTAB || character == CHAR_FORM ||
                character == CHAR_RETURN;
    halted    = mode == MODE_HALTED;
    flush_start = !halted && ((mode == MODE_LETTERS && !is_letter) ||
                              (mode == MODE_DIGITS && !is_digit));

    res_flush = run_token(mode == MODE_LETTERS, 64'(letter_buffer), 4'(letter_count),
                          letters_overflowed, number_accumulator, number_overflowed,
                          line_count, column_count, token_count);
    res_tail   = '0;
    tail_valid = 1'b0;
    digit_sum  = '0;

    mode_next               = mode;
    letter_buffer_next      = letter_buffer;
    letter_count_next       = letter_count;
    letters_overflowed_next = letters_overflowed;
    number_accumulator_next = number_accumulator;
    number_overflowed_next  = number_overflowed;
    line_count_next         = line_count;
    column_count_next       = column_count;
    token_count_next        = token_count;

    if (flush_start) begin
      mode_next               = MODE_IDLE;
      letter_buffer_next      = '0;
      letter_count_next       = '0;
      letters_overflowed_next = 1'b0;
      number_accumulator_next = '0;
      number_overflowed_next  = 1'b0;
      column_count_next       = sat_inc(column_count);
      token_count_next        = sat_inc(token_count);
    end

    if (!halted) begin
      if (is_letter) begin
        mode_next = MODE_LETTERS;
        if (letter_count_next < CntW'(MNEMONIC_CHARS)) begin
          for (int i = 0; i < MNEMONIC_CHARS; i++) begin
            if (letter_count_next == CntW'(i)) letter_buffer_next[8*i +: 8] = character;
          end
          letter_count_next = letter_count_next + CntW'(1);
        end else begin
          letters_overflowed_next = 1'b1;
        end
      end else if (is_digit) begin
        mode_next = MODE_DIGITS;
        digit_sum = 20'(number_accumulator_next) * 20'd10 + 20'(character[3:0]);
        if (digit_sum > 20'(SAT_MAX)) begin
          number_accumulator_next = SAT_MAX;
          number_overflowed_next  = 1'b1;
        end else begin
          number_accumulator_next = digit_sum[15:0];
        end
      end else if (character == CHAR_COMMA) begin
        tail_valid                = 1'b1;
        res_tail.token_kind       = KIND_COMMA;
        res_tail.line_number      = line_count_next;
        res_tail.column_position  = column_count_next;
        res_tail.token_index      = token_count_next;
        token_count_next          = sat_inc(token_count_next);
        column_count_next         = sat_inc(column_count_next);
      end else if (character == CHAR_NEWLINE) begin
        line_count_next   = sat_inc(line_count);
        column_count_next = '0;
      end else if (is_space) begin
        column_count_next = sat_inc(column_count_next);
      end else begin
        tail_valid               = 1'b1;
        res_tail.token_kind      = KIND_ERROR;
        res_tail.line_number     = line_count_next;
        res_tail.column_position = column_count_next;
        res_tail.token_index     = token_count_next;
        mode_next                = MODE_HALTED;
      end
    end

    if (end_of_source) begin
      // A run still open after this byte can only follow a letter or digit,
      // so the tail slot is free for it.
      if (mode_next == MODE_LETTERS || mode_next == MODE_DIGITS) begin
        tail_valid = 1'b1;
        res_tail   = run_token(mode_next == MODE_LETTERS, 64'(letter_buffer_next),
                               4'(letter_count_next), letters_overflowed_next,
                               number_accumulator_next, number_overflowed_next,
                               line_count_next, column_count_next, token_count_next);
      end
      mode_next               = MODE_IDLE;
      letter_buffer_next      = '0;
      letter_count_next       = '0;
      letters_overflowed_next = 1'b0;
      number_accumulator_next = '0;
      number_overflowed_next  = 1'b0;
      line_count_next         = '0;
      column_count_next       = '0;
      token_count_next        = '0;
    end

    res_flush.last_of_run = !tail_valid;
    res_tail.last_of_run  = 1'b1;
    res_first  = flush_start ? res_flush : res_tail;
    res_second = res_tail;
    res_count  = 2'(flush_start) + 2'(tail_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_IDLE;
      letter_buffer      <= '0;
      letter_count       <= '0;
      letters_overflowed <= 1'b0;
      number_accumulator <= '0;
      number_overflowed  <= 1'b0;
      line_count         <= '0;
      column_count       <= '0;
      token_count        <= '0;
    end else if (go) begin
      mode               <= mode_next;
      letter_buffer      <= letter_buffer_next;
      letter_count       <= letter_count_next;
      letters_overflowed <= letters_overflowed_next;
      number_accumulator <= number_accumulator_next;
      number_overflowed  <= number_overflowed_next;
      line_count         <= line_count_next;
      column_count       <= column_count_next;
      token_count        <= token_count_next;
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    go && end_of_source |=> mode == MODE_IDLE && token_count == '0 && line_count == '0)
    else $error("state not cleared after end of source");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    letter_count <= CntW'(MNEMONIC_CHARS))
    else $error("letter count beyond mnemonic capacity");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_HALTED |-> res_count == 2'd0)
    else $error("halted lexer produced a result");

endmodule

// ===== design/asl_out_fifo.sv =====
module asl_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       need,
  output logic             fits,
  input  logic [1:0]       push_count,
  input  asl_pkg::result_t push_first,
  input  asl_pkg::result_t push_second,
  asl_out_if.source        tokens
);
  import asl_pkg::*;

  localparam int Depth = 4;

  result_t     entries [Depth];
  logic [1:0]  rd_ptr, wr_ptr;
  logic [2:0]  count, count_next;
  logic        pop;
  logic [2:0]  count_after_pop;
  result_t     head;

  assign pop             = count != 3'd0 && tokens.ready;
  assign count_after_pop = count - 3'(pop);
  assign fits            = 4'(count_after_pop) + 4'(need) <= 4'(Depth);
  assign count_next      = count_after_pop + 3'(push_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + 2'(pop);
      wr_ptr <= wr_ptr + push_count;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push_first;
    if (push_count == 2'd2) entries[wr_ptr + 2'd1] <= push_second;
  end

  assign head = entries[rd_ptr];

  assign tokens.valid               = count != 3'd0;
  assign tokens.token_kind          = head.token_kind;
  assign tokens.mnemonic_chars      = head.mnemonic_chars;
  assign tokens.mnemonic_length     = head.mnemonic_length;
  assign tokens.mnemonic_too_long   = head.mnemonic_too_long;
  assign tokens.number_value        = head.number_value;
  assign tokens.number_out_of_range = head.number_out_of_range;
  assign tokens.line_number         = head.line_number;
  assign tokens.column_position     = head.column_position;
  assign tokens.token_index         = head.token_index;
  assign tokens.last_of_run         = head.last_of_run;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    4'(count_after_pop) + 4'(push_count) <= 4'(Depth))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(Depth))
    else $error("result queue count out of range");

endmodule

// ===== design/assembler_source_lexer.sv =====
// Channel  | Direction | Transaction
// ---------+-----------+-----------------------------------------------
// source   | in        | one source byte plus its end-of-source mark
// tokens   | out       | one token or error result, last_of_run on the last
//
// A byte is registered on acceptance and its zero, one or two results are
// written into a four-entry result queue once the queue has room for them.
// With the queue draining, one byte is taken per cycle; a byte that yields
// two results needs two output transactions, so the output port bounds the rate.
// A byte waits in the input register while the queue lacks room for its results.
// Reset (rst, synchronous) clears the lexer state and empties the queue.
module assembler_source_lexer #(
  parameter int MNEMONIC_CHARS = 8
) (
  input logic        clk,
  input logic        rst,
  asl_in_if.sink     source,
  asl_out_if.source  tokens
);
  import asl_pkg::*;

  logic       in_valid;
  logic [7:0] in_character;
  logic       in_end_of_source;
  logic       commit, fits;
  logic [1:0] res_count;
  result_t    res_first, res_second;

  assign commit       = in_valid && fits;
  assign source.ready = !in_valid || commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (source.ready) begin
      in_valid <= source.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (source.ready && source.valid) begin
      in_character     <= source.character;
      in_end_of_source <= source.end_of_source;
    end
  end

  asl_core #(.MNEMONIC_CHARS(MNEMONIC_CHARS)) u_core (
    .clk           (clk),
    .rst           (rst),
    .go            (commit),
    .character     (in_character),
    .end_of_source (in_end_of_source),
    .res_first     (res_first),
    .res_second    (res_second),
    .res_count     (res_count)
  );

  asl_out_fifo u_out_fifo (
    .clk         (clk),
    .rst         (rst),
    .need        (res_count),
    .fits        (fits),
    .push_count  (commit ? res_count : 2'd0),
    .push_first  (res_first),
    .push_second (res_second),
    .tokens      (tokens)
  );

endmodule
